// ===== hw/rtl/btnf_pkg.sv =====
// package for the binomial tree neighbour finder
// holds widths, limits, reset values, codes, sequencer states and the modular unit request type
// used by btnf_modunit, binomial_tree_neighbour_finder, tree_walk_checker and testbench
`default_nettype none

package btnf_pkg;

    localparam int RANK_W   = 10;
    localparam int SIZE_W   = 11;
    localparam int CAP_W    = 5;
    localparam int CNT_W    = 4;
    localparam int KIND_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [SIZE_W-1:0] MAX_RANKS   = SIZE_W'(1024);
    localparam logic [CNT_W-1:0]  CHILD_LIMIT = CNT_W'(10);

    localparam logic [SIZE_W-1:0] GROUP_SIZE_RST = SIZE_W'(1);
    localparam logic [CAP_W-1:0]  CAPACITY_RST   = CAP_W'(16);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GROUP_SIZE     = 2'd0,
        CFG_ROOT_RANK      = 2'd1,
        CFG_TREE_DIRECTION = 2'd2,
        CFG_CHILD_CAPACITY = 2'd3
    } cfg_idx_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PARENT = 3'd0,
        KIND_CHILD  = 3'd1,
        KIND_OK     = 3'd2,
        KIND_FULL   = 3'd3,
        KIND_BAD    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_PARENT,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef enum logic {
        MOD_ROT,
        MOD_UNROT
    } mod_op_t;

    typedef struct packed {
        mod_op_t           op;
        logic [SIZE_W-1:0] a;
        logic [SIZE_W-1:0] b;
        logic [SIZE_W-1:0] size;
    } mod_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/btnf_modunit.sv =====
// shared modular add / subtract unit for rank rotation
// rot: (a - b) mod size, unrot: (a + b) mod size, operands below size
// depends on btnf_pkg
`default_nettype none

module btnf_modunit
    import btnf_pkg::*;
(
    input  mod_req_t          req,
    output logic [SIZE_W-1:0] result
);

    logic [SIZE_W:0] ext_a;
    logic [SIZE_W:0] ext_b;
    logic [SIZE_W:0] ext_s;
    logic [SIZE_W:0] diff;
    logic [SIZE_W:0] diff_wrap;
    logic [SIZE_W:0] sum;
    logic [SIZE_W:0] sum_red;

    assign ext_a     = {1'b0, req.a};
    assign ext_b     = {1'b0, req.b};
    assign ext_s     = {1'b0, req.size};
    assign diff      = ext_a - ext_b;
    assign diff_wrap = diff + ext_s;
    assign sum       = ext_a + ext_b;
    assign sum_red   = sum - ext_s;

    always_comb begin
        case (req.op)
            MOD_ROT:   result = diff[SIZE_W] ? diff_wrap[SIZE_W-1:0] : diff[SIZE_W-1:0];
            MOD_UNROT: result = sum_red[SIZE_W] ? sum[SIZE_W-1:0] : sum_red[SIZE_W-1:0];
            default:   result = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/binomial_tree_neighbour_finder.sv =====
// binomial tree neighbour finder top level: sequencer, config registers, output register
// depends on btnf_pkg and btnf_modunit
//
// channel   direction  handshake        payload
// s_        in         s_valid/s_ready  s_member_rank
// m_        out        m_valid/m_ready  m_entry_kind, m_peer_rank, m_last
// cfg_      in         cfg_we           cfg_index, cfg_wdata
//
// one item at a time: a setup state; left mode adds an msb scan state and a parent state,
// then one result per cycle unless m_ is stalled; right mode takes one cycle per mask bit,
// at most 11 mask bits, unless m_ is stalled; a new item waits until the last one is finished
// s_ready is high only while the sequencer is idle; an m_ stall holds every state but idle and the scan
// aresetn is synchronous active low and restores register defaults
`default_nettype none

module binomial_tree_neighbour_finder
    import btnf_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire  [RANK_W-1:0]    s_member_rank,
    output logic                 m_valid,
    input  wire                  m_ready,
    output logic [KIND_W-1:0]    m_entry_kind,
    output logic [RANK_W-1:0]    m_peer_rank,
    output logic                 m_last,
    input  wire                  cfg_we,
    input  wire  [CFG_IDX_W-1:0] cfg_index,
    input  wire  [SIZE_W-1:0]    cfg_wdata
);

    logic [SIZE_W-1:0] group_size_reg;
    logic [RANK_W-1:0] root_reg;
    logic              dir_reg;
    logic [CAP_W-1:0]  cap_reg;

    state_t            state_reg, state_next;
    logic [RANK_W-1:0] rank_reg;
    logic [RANK_W-1:0] rot_reg, rot_next;
    logic [SIZE_W-1:0] mask_reg, mask_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              m_valid_reg;
    kind_t             m_kind_reg;
    logic [RANK_W-1:0] m_peer_reg;
    logic              m_last_reg;

    logic [SIZE_W-1:0] size_eff;
    logic [CNT_W-1:0]  cap_eff;
    logic              step_en;
    logic              bad;
    logic [SIZE_W-1:0] rot_ext;
    logic [SIZE_W-1:0] walk_t;
    logic [SIZE_W-1:0] parent_val;
    logic              mask_lt_size;
    logic              t_lt_size;
    logic              bit_set;
    logic              cap_hit;

    mod_req_t          mod_req;
    logic [SIZE_W-1:0] mod_res;

    logic              emit;
    kind_t             emit_kind;
    logic [RANK_W-1:0] emit_peer;
    logic              emit_last;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_size_reg <= GROUP_SIZE_RST;
            root_reg       <= '0;
            dir_reg        <= 1'b0;
            cap_reg        <= CAPACITY_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_GROUP_SIZE:     group_size_reg <= cfg_wdata;
                CFG_ROOT_RANK:      root_reg       <= cfg_wdata[RANK_W-1:0];
                CFG_TREE_DIRECTION: dir_reg        <= cfg_wdata[0];
                CFG_CHILD_CAPACITY: cap_reg        <= cfg_wdata[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    assign size_eff = (group_size_reg > MAX_RANKS) ? MAX_RANKS : group_size_reg;
    assign cap_eff  = (cap_reg > CAP_W'(CHILD_LIMIT)) ? CHILD_LIMIT : cap_reg[CNT_W-1:0];

    assign step_en      = !m_valid_reg || m_ready;
    assign rot_ext      = {1'b0, rot_reg};
    assign bad          = (size_eff == '0) || ({1'b0, rank_reg} >= size_eff)
                          || ({1'b0, root_reg} >= size_eff);
    assign walk_t       = rot_ext ^ mask_reg;
    assign parent_val   = rot_ext ^ (mask_reg >> 1);
    assign mask_lt_size = mask_reg < size_eff;
    assign t_lt_size    = walk_t < size_eff;
    assign bit_set      = |(rot_ext & mask_reg);
    assign cap_hit      = cnt_reg >= cap_eff;

    btnf_modunit u_modunit (
        .req    (mod_req),
        .result (mod_res)
    );

    // result selection and shared unit operands
    always_comb begin
        emit         = 1'b0;
        emit_kind    = KIND_OK;
        emit_last    = 1'b0;
        mod_req.op   = MOD_UNROT;
        mod_req.a    = walk_t;
        mod_req.b    = {1'b0, root_reg};
        mod_req.size = size_eff;
        case (state_reg)
            ST_SETUP: begin
                mod_req.op = MOD_ROT;
                mod_req.a  = {1'b0, rank_reg};
                if (bad) begin
                    emit      = 1'b1;
                    emit_kind = KIND_BAD;
                    emit_last = 1'b1;
                end
            end
            ST_PARENT: begin
                mod_req.a = parent_val;
                if (rot_reg != '0) begin
                    emit      = 1'b1;
                    emit_kind = KIND_PARENT;
                end
            end
            ST_WALK: begin
                if (!mask_lt_size) begin
                    emit      = 1'b1;
                    emit_kind = KIND_OK;
                    emit_last = 1'b1;
                end else if (!dir_reg) begin
                    emit = 1'b1;
                    if (!t_lt_size) begin
                        emit_kind = KIND_OK;
                        emit_last = 1'b1;
                    end else if (cap_hit) begin
                        emit_kind = KIND_FULL;
                        emit_last = 1'b1;
                    end else begin
                        emit_kind = KIND_CHILD;
                    end
                end else if (bit_set) begin
                    emit      = 1'b1;
                    emit_kind = KIND_PARENT;
                end else if (t_lt_size) begin
                    emit = 1'b1;
                    if (cap_hit) begin
                        emit_kind = KIND_FULL;
                        emit_last = 1'b1;
                    end else begin
                        emit_kind = KIND_CHILD;
                    end
                end
            end
            ST_DONE: begin
                emit      = 1'b1;
                emit_kind = KIND_OK;
                emit_last = 1'b1;
            end
            default: ;
        endcase
        if (emit_kind == KIND_PARENT || emit_kind == KIND_CHILD) begin
            emit_peer = mod_res[RANK_W-1:0];
        end else begin
            emit_peer = '0;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_SETUP;
            end
            ST_SETUP: begin
                if (step_en) begin
                    if (bad)          state_next = ST_IDLE;
                    else if (dir_reg) state_next = ST_WALK;
                    else              state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (mask_reg > rot_ext) state_next = ST_PARENT;
            end
            ST_PARENT: begin
                if (step_en) state_next = ST_WALK;
            end
            ST_WALK: begin
                if (step_en && emit) begin
                    if (emit_last)                    state_next = ST_IDLE;
                    else if (emit_kind == KIND_PARENT) state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (step_en) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // walk datapath
    always_comb begin
        rot_next  = rot_reg;
        mask_next = mask_reg;
        cnt_next  = cnt_reg;
        case (state_reg)
            ST_SETUP: begin
                if (step_en && !bad) begin
                    rot_next  = mod_res[RANK_W-1:0];
                    mask_next = SIZE_W'(1);
                    cnt_next  = '0;
                end
            end
            ST_SCAN: begin
                if (mask_reg <= rot_ext) mask_next = mask_reg << 1;
            end
            ST_WALK: begin
                if (step_en) begin
                    if (emit && emit_kind == KIND_CHILD) begin
                        cnt_next  = cnt_reg + CNT_W'(1);
                        mask_next = mask_reg << 1;
                    end else if (!emit) begin
                        mask_next = mask_reg << 1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rot_reg   <= '0;
            mask_reg  <= SIZE_W'(1);
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            rot_reg   <= rot_next;
            mask_reg  <= mask_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            rank_reg <= s_member_rank;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_en) begin
            m_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && emit) begin
            m_kind_reg <= emit_kind;
            m_peer_reg <= emit_peer;
            m_last_reg <= emit_last;
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_entry_kind = m_kind_reg;
    assign m_peer_rank  = m_peer_reg;
    assign m_last       = m_last_reg;

    a_mask_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(mask_reg))
        else $error("walk mask lost its single bit");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (cnt_reg <= cap_eff))
        else $error("child count above capacity");

    a_accept_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SETUP))
        else $error("accepted item did not start setup");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && emit && emit_last) |=> (state_reg == ST_IDLE))
        else $error("sequencer busy after final item");

    a_status_peer: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && emit && emit_last) |-> (emit_peer == '0))
        else $error("status item carries a peer rank");

endmodule

`default_nettype wire

// ===== tb/tree_walk_checker.sv =====
// checker for the binomial tree neighbour finder: tracks register writes, predicts the
// parent, child and status entries of each accepted rank and compares the result channel
// depends on btnf_pkg
`timescale 1ns / 1ps

module tree_walk_checker
    import btnf_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    input  wire                  s_ready,
    input  wire  [RANK_W-1:0]    s_member_rank,
    input  wire                  m_valid,
    input  wire                  m_ready,
    input  wire  [KIND_W-1:0]    m_entry_kind,
    input  wire  [RANK_W-1:0]    m_peer_rank,
    input  wire                  m_last,
    input  wire                  cfg_we,
    input  wire  [CFG_IDX_W-1:0] cfg_index,
    input  wire  [SIZE_W-1:0]    cfg_wdata,
    output int                   fail_count,
    output int                   entries_checked,
    output int                   entries_pending
);

    localparam int RANK_LIMIT  = 1024;
    localparam int CHILD_BOUND = 10;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [RANK_W-1:0] peer;
        logic              last;
    } tree_entry_t;

    tree_entry_t       expected_entries[$];
    logic [SIZE_W-1:0] group_size_q;
    logic [RANK_W-1:0] root_q;
    logic              direction_q;
    logic [CAP_W-1:0]  capacity_q;

    function automatic void push_entry(kind_t kind, int peer, logic last);
        tree_entry_t e;
        e.kind = kind;
        e.peer = RANK_W'(peer);
        e.last = last;
        expected_entries.push_back(e);
    endfunction

    // map a rotated index back to real rank numbering
    function automatic int back_to_rank(int v, int size);
        int s;
        s = v + int'(root_q);
        return (s >= size) ? s - size : s;
    endfunction

    function automatic void walk_tree(logic [RANK_W-1:0] rank);
        int r, root, size, cap, rot, mask, cnt, t, v;
        r    = int'(rank);
        root = int'(root_q);
        size = (int'(group_size_q) > RANK_LIMIT) ? RANK_LIMIT : int'(group_size_q);
        cap  = (int'(capacity_q) > CHILD_BOUND) ? CHILD_BOUND : int'(capacity_q);
        cnt  = 0;
        mask = 1;
        if (size == 0 || r >= size || root >= size) begin
            push_entry(KIND_BAD, 0, 1'b1);
            return;
        end
        rot = (r >= root) ? r - root : r + size - root;
        if (!direction_q) begin
            for (v = rot; v != 0; v = v >> 1)
                mask = mask << 1;
            // parent: highest set bit cleared
            if (rot != 0)
                push_entry(KIND_PARENT, back_to_rank(rot ^ (mask >> 1), size), 1'b0);
            while (mask < size) begin
                t = rot ^ mask;
                if (t >= size)
                    break;
                if (cnt >= cap) begin
                    push_entry(KIND_FULL, 0, 1'b1);
                    return;
                end
                push_entry(KIND_CHILD, back_to_rank(t, size), 1'b0);
                cnt++;
                mask = mask << 1;
            end
        end else begin
            while (mask < size) begin
                t = rot ^ mask;
                if (t < rot) begin
                    push_entry(KIND_PARENT, back_to_rank(t, size), 1'b0);
                    break;
                end
                if (t < size) begin
                    if (cnt >= cap) begin
                        push_entry(KIND_FULL, 0, 1'b1);
                        return;
                    end
                    push_entry(KIND_CHILD, back_to_rank(t, size), 1'b0);
                    cnt++;
                end
                mask = mask << 1;
            end
        end
        push_entry(KIND_OK, 0, 1'b1);
    endfunction

    always @(posedge aclk) begin
        tree_entry_t want;
        if (!aresetn) begin
            group_size_q = GROUP_SIZE_RST;
            root_q       = '0;
            direction_q  = 1'b0;
            capacity_q   = CAPACITY_RST;
            expected_entries.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_GROUP_SIZE:     group_size_q = cfg_wdata;
                    CFG_ROOT_RANK:      root_q       = cfg_wdata[RANK_W-1:0];
                    CFG_TREE_DIRECTION: direction_q  = cfg_wdata[0];
                    CFG_CHILD_CAPACITY: capacity_q   = cfg_wdata[CAP_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_entries.size() == 0) begin
                    $error("unexpected entry: entry_kind %0d peer_rank %0d last %0d",
                           m_entry_kind, m_peer_rank, m_last);
                    fail_count++;
                end else begin
                    want = expected_entries.pop_front();
                    entries_checked++;
                    if (m_entry_kind !== want.kind) begin
                        $error("entry_kind: expected %0d, actual %0d", want.kind, m_entry_kind);
                        fail_count++;
                    end
                    if (m_peer_rank !== want.peer) begin
                        $error("peer_rank: expected %0d, actual %0d", want.peer, m_peer_rank);
                        fail_count++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, m_last);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                walk_tree(s_member_rank);
        end
        entries_pending <= expected_entries.size();
    end

endmodule

// ===== tb/testbench.sv =====
// top of the binomial tree neighbour finder testbench: clock, reset, register writes,
// rank queries and output back-pressure; checking is done by tree_walk_checker
// depends on btnf_pkg, binomial_tree_neighbour_finder and tree_walk_checker
`timescale 1ns / 1ps

module testbench;
    import btnf_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 30;
    localparam int RANDOM_PHASES = 8;
    localparam int QUERIES_PER_PHASE = 50;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic [RANK_W-1:0] s_member_rank = '0;
    logic              m_ready = 1'b0;
    logic              cfg_we = 1'b0;
    cfg_idx_t          cfg_index = CFG_GROUP_SIZE;
    logic [SIZE_W-1:0] cfg_wdata = '0;

    wire               s_ready;
    wire               m_valid;
    wire [KIND_W-1:0]  m_entry_kind;
    wire [RANK_W-1:0]  m_peer_rank;
    wire               m_last;

    int fail_count;
    int entries_checked;
    int entries_pending;
    int queries_sent = 0;
    int settings_used = 0;
    int holds_asked = 0;
    int holds_done = 0;
    bit steady = 1'b0;

    always #4 aclk = ~aclk;

    binomial_tree_neighbour_finder DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_member_rank (s_member_rank),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_entry_kind  (m_entry_kind),
        .m_peer_rank   (m_peer_rank),
        .m_last        (m_last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    tree_walk_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_member_rank   (s_member_rank),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_entry_kind    (m_entry_kind),
        .m_peer_rank     (m_peer_rank),
        .m_last          (m_last),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .entries_checked (entries_checked),
        .entries_pending (entries_pending)
    );

    task automatic send_rank(input logic [RANK_W-1:0] rank);
        while (!steady && $urandom_range(99) < 16) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_member_rank <= rank;
        do @(posedge aclk); while (!s_ready);
        queries_sent++;
    endtask

    // stop offering items until every expected entry is back and the block is idle
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (entries_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_tree(input logic [SIZE_W-1:0] size, input logic [RANK_W-1:0] root,
                                input logic dir, input logic [CAP_W-1:0] cap);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GROUP_SIZE;
        cfg_wdata <= size;
        @(posedge aclk);
        cfg_index <= CFG_ROOT_RANK;
        cfg_wdata <= SIZE_W'(root);
        @(posedge aclk);
        cfg_index <= CFG_TREE_DIRECTION;
        cfg_wdata <= SIZE_W'(dir);
        @(posedge aclk);
        cfg_index <= CFG_CHILD_CAPACITY;
        cfg_wdata <= SIZE_W'(cap);
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // mostly ranks inside the group, the rest anywhere in the field
    function automatic logic [RANK_W-1:0] pick_rank(int size);
        int lim;
        lim = (size > 1024) ? 1024 : size;
        if (lim > 0 && $urandom_range(99) < 85)
            return RANK_W'($urandom_range(lim - 1));
        return RANK_W'($urandom_range(1023));
    endfunction

    // output side back-pressure
    initial begin
        forever begin
            @(posedge aclk);
            if (holds_done != holds_asked) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_done++;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 16);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int p, i, lim;
        logic [SIZE_W-1:0] size;
        logic [RANK_W-1:0] root;
        logic              dir;
        logic [CAP_W-1:0]  cap;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults: a group of one
        send_rank(0);
        send_rank(1023);
        settle();

        // full group, left walk, root 0 fills exactly ten children
        program_tree(1024, 0, 1'b0, 16);
        send_rank(0);
        send_rank(1023);
        send_rank(512);
        send_rank(1);
        send_rank(682);
        send_rank(341);
        settle();

        // right walk with the root at the top rank
        program_tree(1024, 1023, 1'b1, 10);
        send_rank(1023);
        send_rank(0);
        send_rank(511);
        settle();

        // left walk overflowing a small capacity, plus a rank past the group
        program_tree(13, 5, 1'b0, 2);
        send_rank(5);
        send_rank(4);
        send_rank(13);
        send_rank(12);
        settle();

        // empty group
        program_tree(0, 0, 1'b1, 0);
        send_rank(0);
        settle();

        // oversized group clamps, zero capacity overflows at the root's first child
        program_tree(2047, 3, 1'b1, 0);
        send_rank(3);
        send_rank(2);
        settle();

        // root outside the group
        program_tree(7, 9, 1'b0, 31);
        send_rank(0);
        settle();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: size = SIZE_W'($urandom_range(64, 1));
                4, 5, 6, 7: size = SIZE_W'($urandom_range(1024, 65));
                8:          size = SIZE_W'(1024);
                default:    size = SIZE_W'($urandom_range(2047));
            endcase
            lim = (size > 1024) ? 1024 : int'(size);
            if (lim == 0 || $urandom_range(9) == 0)
                root = RANK_W'($urandom_range(1023));
            else
                root = RANK_W'($urandom_range(lim - 1));
            dir = 1'($urandom_range(1));
            if ($urandom_range(7) == 0)
                cap = CAP_W'($urandom_range(31, 17));
            else
                cap = CAP_W'($urandom_range(16));
            program_tree(size, root, dir, cap);
            steady = (p == 5);
            for (i = 0; i < QUERIES_PER_PHASE; i++) begin
                if (p == 2 && i == 5)
                    holds_asked++;
                send_rank(pick_rank(int'(size)));
            end
            settle();
            steady = 1'b0;
        end

        $display("summary: %0d rank queries under %0d register settings, %0d entries checked",
                 queries_sent, settings_used, entries_checked);
        $display("summary: left and right walks, bad ranks, capacity overflow, size clamp,");
        $display("summary: %0d-cycle output stall", HOLD_CYCLES);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/btnf_pkg.sv
hw/rtl/btnf_modunit.sv
hw/rtl/binomial_tree_neighbour_finder.sv
tb/tree_walk_checker.sv
tb/testbench.sv
